### rtl/core/dcsg_pkg.sv
// dcsg_pkg: shared widths, sample types and the quarter-wave sine table
// for the dual channel sine generator; depends on nothing else
package dcsg_pkg;

	// phase and table geometry
	localparam int PHASE_BITS      = 32;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int TABLE_DEPTH     = (1 << TABLE_ADDR_BITS) + 1;
	localparam int STEP_BITS       = 32;
	localparam int AMP_BITS        = 15;
	localparam int ENTRY_BITS      = 15;
	localparam int SAMPLE_BITS     = 16;

	// step alignment shifts, at most one of them is nonzero
	localparam int STEP_SHL = (PHASE_BITS >= STEP_BITS) ? PHASE_BITS - STEP_BITS : 0;
	localparam int STEP_SHR = (PHASE_BITS < STEP_BITS) ? STEP_BITS - PHASE_BITS : 0;

	// configuration register map (byte address 4*index)
	localparam int CFG_ADDR_BITS = 4;
	localparam logic [1:0] REG_LEFT_STEP  = 2'd0;
	localparam logic [1:0] REG_RIGHT_STEP = 2'd1;
	localparam logic [1:0] REG_AMPLITUDE  = 2'd2;

	// reset values
	localparam logic [STEP_BITS-1:0]  LEFT_STEP_RST  = 32'd322122547;
	localparam logic [STEP_BITS-1:0]  RIGHT_STEP_RST = 32'd322927854;
	localparam logic [AMP_BITS-1:0]   AMPLITUDE_RST  = 15'd15000;
	localparam logic [PHASE_BITS-1:0] PHASE_RST      = {1'b1, {(PHASE_BITS-1){1'b0}}};

	// pi/2 in unsigned Q2.30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [PHASE_BITS-1:0]         phase_t;
	typedef logic [STEP_BITS-1:0]          step_t;
	typedef logic [AMP_BITS-1:0]           amp_t;
	typedef logic [ENTRY_BITS-1:0]         entry_t;
	typedef logic [TABLE_ADDR_BITS:0]      taddr_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef entry_t                        qtab_t [TABLE_DEPTH];

	// phase step aligned to the phase width
	function automatic phase_t align_step(input step_t step);
		phase_t r;
		if (PHASE_BITS >= STEP_BITS) begin
			r = phase_t'(step) << STEP_SHL;
		end else begin
			r = phase_t'(step >> STEP_SHR);
		end
		return r;
	endfunction

	// next odd power term x^(2n+1) from x^(2n-1), all in Q2.30
	function automatic logic [63:0] pow_step(input logic [63:0] t, input logic [63:0] x);
		logic [63:0] p;
		p = (t * x) >> 30;
		p = (p * x) >> 30;
		return p;
	endfunction

	// subtract clamped at zero
	function automatic logic [63:0] sub_clamp(input logic [63:0] s, input logic [63:0] t);
		return (t > s) ? 64'd0 : s - t;
	endfunction

	// one quarter-wave entry, Taylor series to x^15, rounded to unsigned Q0.15
	function automatic entry_t quarter_entry(input int k);
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] t;
		logic [63:0] r;
		x = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
		s = x;
		t = x;
		t = pow_step(t, x) / 64'd6;   s = sub_clamp(s, t);
		t = pow_step(t, x) / 64'd20;  s = s + t;
		t = pow_step(t, x) / 64'd42;  s = sub_clamp(s, t);
		t = pow_step(t, x) / 64'd72;  s = s + t;
		t = pow_step(t, x) / 64'd110; s = sub_clamp(s, t);
		t = pow_step(t, x) / 64'd156; s = s + t;
		t = pow_step(t, x) / 64'd210; s = sub_clamp(s, t);
		r = (s + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return entry_t'(r);
	endfunction

	// whole table, built at elaboration
	function automatic qtab_t build_qtab();
		qtab_t tab;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			tab[k] = quarter_entry(k);
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

endpackage

### rtl/core/dcsg_req_if.sv
// dcsg_req_if: valid/ready channel that carries sample requests
// depends on nothing else
interface dcsg_req_if;
	logic valid;
	logic ready;
	logic sample_request;

	modport source (output valid, output sample_request, input ready);
	modport sink   (input valid, input sample_request, output ready);
endinterface

### rtl/core/dcsg_smp_if.sv
// dcsg_smp_if: valid/ready channel that carries one stereo sample pair
// depends on dcsg_pkg for the sample type
interface dcsg_smp_if;
	logic             valid;
	logic             ready;
	dcsg_pkg::sample_t left_sample;
	dcsg_pkg::sample_t right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

### rtl/core/dual_channel_sine_generator.sv
// dual_channel_sine_generator: two-channel sine oscillator with APB config
// depends on dcsg_pkg, dcsg_req_if and dcsg_smp_if
//
// Usage:
//   req: one transaction per request; sample_request = 1 asks for the next
//        stereo pair, a transaction with sample_request = 0 is taken and
//        dropped with no result and no phase change.
//   smp: one transaction per pair, left_sample and right_sample signed 16 bit.
//   APB: left step at 0x0, right step at 0x4, amplitude at 0x8; pready is
//        always high, writes land on the access cycle. Write only when idle.
// Pipeline: a pair goes through the sine table read register, then multiply
//   and sign into the output register that drives smp.
// Throughput: one request per cycle except while a stall holds req.ready low;
//   the phase add and the table read share the first stage, the 15x15
//   multiply and sign fill the second.
// Reset: both phases go to a half turn, registers to their defaults, the
//   pipeline empties.
// Stall: while smp is held off the output register and the table stage
//   keep their pair; req.ready drops only once both stages are full.
module dual_channel_sine_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	dcsg_req_if.sink                              req,
	dcsg_smp_if.source                            smp,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [dcsg_pkg::CFG_ADDR_BITS-1:0]    paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	dcsg_pkg::step_t  left_step_q;
	dcsg_pkg::step_t  right_step_q;
	dcsg_pkg::amp_t   amplitude_q;
	dcsg_pkg::phase_t left_phase_q;
	dcsg_pkg::phase_t right_phase_q;

	logic             cfg_wr;
	logic [1:0]       cfg_idx;
	logic             req_take;
	logic             advance;

	dcsg_pkg::taddr_t left_addr;
	dcsg_pkg::taddr_t right_addr;

	logic             valid_s1;
	dcsg_pkg::entry_t left_entry_s1;
	dcsg_pkg::entry_t right_entry_s1;
	logic             left_neg_s1;
	logic             right_neg_s1;

	logic [dcsg_pkg::AMP_BITS+dcsg_pkg::ENTRY_BITS-1:0] left_prod;
	logic [dcsg_pkg::AMP_BITS+dcsg_pkg::ENTRY_BITS-1:0] right_prod;
	dcsg_pkg::sample_t left_smp;
	dcsg_pkg::sample_t right_smp;

	logic              valid_s2;
	dcsg_pkg::sample_t left_sample_s2;
	dcsg_pkg::sample_t right_sample_s2;

	// apb decode
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_idx)
			dcsg_pkg::REG_LEFT_STEP:  prdata = left_step_q;
			dcsg_pkg::REG_RIGHT_STEP: prdata = right_step_q;
			dcsg_pkg::REG_AMPLITUDE:  prdata = {17'd0, amplitude_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_step_q  <= dcsg_pkg::LEFT_STEP_RST;
			right_step_q <= dcsg_pkg::RIGHT_STEP_RST;
			amplitude_q  <= dcsg_pkg::AMPLITUDE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				dcsg_pkg::REG_LEFT_STEP:  left_step_q  <= pwdata;
				dcsg_pkg::REG_RIGHT_STEP: right_step_q <= pwdata;
				dcsg_pkg::REG_AMPLITUDE:  amplitude_q  <= pwdata[dcsg_pkg::AMP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign advance   = !valid_s2 || smp.ready;
	assign req.ready = !valid_s1 || advance;
	assign req_take  = req.valid && req.ready && req.sample_request;

	// phase accumulators advance on each taken request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_phase_q  <= dcsg_pkg::PHASE_RST;
			right_phase_q <= dcsg_pkg::PHASE_RST;
		end else if (req_take) begin
			left_phase_q  <= left_phase_q + dcsg_pkg::align_step(left_step_q);
			right_phase_q <= right_phase_q + dcsg_pkg::align_step(right_step_q);
		end
	end

	// quarter-wave fold: odd quadrants read the table mirrored
	function automatic dcsg_pkg::taddr_t fold_addr(input dcsg_pkg::phase_t ph);
		dcsg_pkg::taddr_t idx;
		idx = {1'b0, ph[dcsg_pkg::PHASE_BITS-3 -: dcsg_pkg::TABLE_ADDR_BITS]};
		if (ph[dcsg_pkg::PHASE_BITS-2]) begin
			idx = dcsg_pkg::taddr_t'(1 << dcsg_pkg::TABLE_ADDR_BITS) - idx;
		end
		return idx;
	endfunction

	assign left_addr  = fold_addr(left_phase_q);
	assign right_addr = fold_addr(right_phase_q);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req_take;
		end
	end

	// stage 1: registered sine table read and quadrant sign
	always_ff @(posedge clk) begin
		if (req_take) begin
			left_entry_s1  <= dcsg_pkg::QTAB[left_addr];
			right_entry_s1 <= dcsg_pkg::QTAB[right_addr];
			left_neg_s1    <= left_phase_q[dcsg_pkg::PHASE_BITS-1];
			right_neg_s1   <= right_phase_q[dcsg_pkg::PHASE_BITS-1];
		end
	end

	// amplitude scaling, truncated toward zero, then sign
	assign left_prod  = amplitude_q * left_entry_s1;
	assign right_prod = amplitude_q * right_entry_s1;

	always_comb begin
		left_smp  = dcsg_pkg::sample_t'({1'b0, left_prod[29:15]});
		right_smp = dcsg_pkg::sample_t'({1'b0, right_prod[29:15]});
		if (left_neg_s1) begin
			left_smp = -left_smp;
		end
		if (right_neg_s1) begin
			right_smp = -right_smp;
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			left_sample_s2  <= left_smp;
			right_sample_s2 <= right_smp;
		end
	end

	assign smp.valid        = valid_s2;
	assign smp.left_sample  = left_sample_s2;
	assign smp.right_sample = right_sample_s2;

endmodule
